// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LRU_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lru assertion failed");

// next-cycle implication
`define LRU_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lru assertion failed");

`endif

// ===== hw/rtl/lru_pkg.sv =====
package lru_pkg;

  localparam int PAGE_W        = 4;
  localparam int MODE_W        = 2;
  localparam int CAP_W         = 5;
  localparam int NUM_PAGES_DEF = 16;
  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_ACCESS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EVICT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } lru_cmd_t;

  typedef struct packed {
    logic                hit;
    logic                victim_valid;
    logic [PAGE_W-1:0]   victim_page;
    logic                removed;
  } lru_result_t;

endpackage

// ===== hw/rtl/lru_ctrl.sv =====
module lru_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lru_pkg::lru_cmd_t cmd
);
  import lru_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  // update only once the output register is free
  assign cmd.commit  = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/lru_dp.sv =====
module lru_dp #(
  parameter int NUM_PAGES = lru_pkg::NUM_PAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lru_pkg::lru_cmd_t          cmd,
  input  logic [lru_pkg::MODE_W-1:0] in_mode,
  input  logic [lru_pkg::PAGE_W-1:0] in_page,
  input  logic                       cfg_we,
  input  logic [lru_pkg::CAP_W-1:0]  cfg_cap,
  output lru_pkg::lru_result_t       result
);
  import lru_pkg::*;

  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int CNT_W = $clog2(NUM_PAGES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int PRG_W = 7;

  // recency list, position 0 most recent
  logic [PAGE_W-1:0] order_r   [NUM_PAGES];
  logic [PAGE_W-1:0] order_nxt [NUM_PAGES];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;

  // latched item and compare results
  logic [MODE_W-1:0]    mode_r;
  logic [PAGE_W-1:0]    page_r;
  logic                 pvalid_r;
  logic                 hit_r;
  logic [NUM_PAGES-1:0] le_r, ge_r;

  logic [NUM_PAGES-1:0] match, le, ge;
  lru_result_t          res_r, res_nxt;

  logic [CNT_W-1:0]  cntm1;
  logic [IDX_W-1:0]  lru_idx;
  logic [PAGE_W-1:0] lru_page;
  logic [CMP_W-1:0]  ecap;
  logic              full;

  // one-hot position compare; le marks positions at or past the match, ge up to it
  always_comb begin
    for (int i = 0; i < NUM_PAGES; i++) begin
      match[i] = (order_r[i] == in_page) && (CNT_W'(i) < count_r);
    end
    for (int i = 0; i < NUM_PAGES; i++) begin
      le[i] = 1'b0;
      ge[i] = 1'b0;
      for (int j = 0; j < NUM_PAGES; j++) begin
        if (j <= i) begin
          le[i] = le[i] | match[j];
        end
        if (j >= i) begin
          ge[i] = ge[i] | match[j];
        end
      end
    end
  end

  assign cntm1    = count_r - CNT_W'(1);
  assign lru_idx  = cntm1[IDX_W-1:0];
  assign lru_page = order_r[lru_idx];

  always_comb begin
    ecap = CMP_W'(cap_r);
    if (cap_r == '0) begin
      ecap = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(NUM_PAGES)) begin
      ecap = CMP_W'(NUM_PAGES);
    end
  end

  assign full = (CMP_W'(count_r) >= ecap) && (count_r != '0);

  always_comb begin
    for (int i = 0; i < NUM_PAGES; i++) begin
      order_nxt[i] = order_r[i];
    end
    count_nxt = count_r;
    res_nxt   = '0;
    case (mode_r)
      MODE_ACCESS: begin
        if (pvalid_r) begin
          if (hit_r) begin
            res_nxt.hit = 1'b1;
            for (int i = 1; i < NUM_PAGES; i++) begin
              if (ge_r[i]) begin
                order_nxt[i] = order_r[i-1];
              end
            end
          end else begin
            if (full) begin
              res_nxt.victim_valid = 1'b1;
              res_nxt.victim_page  = lru_page;
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
            for (int i = 1; i < NUM_PAGES; i++) begin
              order_nxt[i] = order_r[i-1];
            end
          end
          order_nxt[0] = page_r;
        end
      end
      MODE_EVICT: begin
        if (count_r != '0) begin
          res_nxt.victim_valid = 1'b1;
          res_nxt.victim_page  = lru_page;
          count_nxt            = cntm1;
        end
      end
      MODE_REMOVE: begin
        if (pvalid_r && hit_r) begin
          res_nxt.removed = 1'b1;
          count_nxt       = cntm1;
          for (int i = 0; i < NUM_PAGES - 1; i++) begin
            if (le_r[i]) begin
              order_nxt[i] = order_r[i+1];
            end
          end
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_cap;
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_mode;
      page_r   <= in_page;
      pvalid_r <= (PRG_W'(in_page) < PRG_W'(NUM_PAGES));
      hit_r    <= |match;
      le_r     <= le;
      ge_r     <= ge;
    end
    if (cmd.commit) begin
      res_r <= res_nxt;
      for (int i = 0; i < NUM_PAGES; i++) begin
        order_r[i] <= order_nxt[i];
      end
    end
  end

  assign result = res_r;

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
// the accepted item is latched with its compare results, and the result is registered
//   when the update commits; no new item is taken until that commit, since the compare on
//   the recency list is followed by the shift-update of that same list
// a stalled output holds the next item in the compare register until it drains
// reset: synchronous active-low; list empty, capacity 16, no clearing pass
module lru_page_replacement #(
  parameter int NUM_PAGES = lru_pkg::NUM_PAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lru_pkg::IN_DATA_W-1:0]  in_tdata,   // [3:0] page, [7:4] zero
  input  logic [lru_pkg::MODE_W-1:0]     in_tuser,   // [1:0] mode
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lru_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] hit, [1] victim_valid,
                                                     // [5:2] victim_page, [6] removed,
                                                     // [7] zero
  // capacity register write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lru_pkg::CAP_W-1:0]      cfg_data
);
  import lru_pkg::*;

  `include "assert_macros.svh"

  lru_cmd_t    cmd;
  lru_result_t result;

  // capacity writes are always taken
  assign cfg_ready = 1'b1;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  lru_dp #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_mode (in_tuser),
    .in_page (in_tdata[PAGE_W-1:0]),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_cap (cfg_data),
    .result  (result)
  );

  assign out_tdata = {1'b0, result.removed, result.victim_page,
                      result.victim_valid, result.hit};

  // one item in flight: no accept right after an accept
  `LRU_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  // victim page reads zero when no page was evicted
  `LRU_ASSERT_IMP(a_victim_zero, out_tvalid && !out_tdata[1], out_tdata[5:2] == 4'd0)
  // hit and removed never come from the same item
  `LRU_ASSERT_IMP(a_hit_or_removed, out_tvalid, !(out_tdata[0] && out_tdata[6]))
  // a remove never reports a victim
  `LRU_ASSERT_IMP(a_remove_no_victim, out_tvalid && out_tdata[6], !out_tdata[1])

endmodule

// ===== test/lru_page_replacement_tb.sv =====
`timescale 1ns / 100ps

module lru_page_replacement_tb;
  import lru_pkg::*;

  localparam int NPAGES = NUM_PAGES_DEF;
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;  // unused code, block must ignore it

  // receiver behavior, picked per phase
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_stall_t;

  // one input item: selector in tuser, page in tdata
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] page;
  } page_req_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_data = '0;

  lru_page_replacement #(.NUM_PAGES(NPAGES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // items waiting to go out, and results the policy should produce
  page_req_t   req_q[$];
  lru_result_t expected_q[$];
  int          fail_count = 0;

  // sender burst/gap shaping and receiver stall mode, set per phase
  bit        gaps_on = 1'b1;
  int        burst_left = 1;
  int        gap_left = 0;
  rx_stall_t rx_mode = RX_FREE;
  int        rx_tick = 0;

  // shadow of the policy: recency list, residency bits, fill count, capacity
  logic [PAGE_W-1:0] lru_order[NPAGES];
  logic              lru_resident[NPAGES];
  int                lru_count;
  logic [CAP_W-1:0]  cap_shadow;

  // capacity 0 acts as 1, anything above the page count acts as the page count
  function automatic int usable_frames(logic [CAP_W-1:0] c);
    if (c == 0) return 1;
    if (c > NPAGES) return NPAGES;
    return int'(c);
  endfunction

  // position of a resident page in the recency list
  function automatic int position_of(logic [PAGE_W-1:0] p);
    for (int i = 0; i < lru_count; i++)
      if (lru_order[i] == p) return i;
    return lru_count;
  endfunction

  // drop the least recent entry and report it
  task automatic evict_oldest(output logic [PAGE_W-1:0] vp);
    vp = lru_order[lru_count-1];
    lru_resident[vp] = 1'b0;
    lru_count--;
  endtask

  // apply one item to the shadow list and return what the block should answer
  task automatic update_recency(input page_req_t req, output lru_result_t res);
    int pos;
    logic [PAGE_W-1:0] vp;
    res = '0;
    case (req.mode)
      MODE_ACCESS: begin
        if (lru_resident[req.page]) begin
          // hit: pull the page up to the front
          res.hit = 1'b1;
          pos = position_of(req.page);
          for (int i = pos; i > 0; i--) lru_order[i] = lru_order[i-1];
          lru_order[0] = req.page;
        end else begin
          // miss: make room once if full, then insert at the front
          if (lru_count >= usable_frames(cap_shadow) && lru_count > 0) begin
            evict_oldest(vp);
            res.victim_valid = 1'b1;
            res.victim_page  = vp;
          end
          if (lru_count < NPAGES) begin
            for (int i = lru_count; i > 0; i--) lru_order[i] = lru_order[i-1];
            lru_order[0] = req.page;
            lru_resident[req.page] = 1'b1;
            lru_count++;
          end
        end
      end
      MODE_EVICT: begin
        // empty list reports no victim
        if (lru_count > 0) begin
          evict_oldest(vp);
          res.victim_valid = 1'b1;
          res.victim_page  = vp;
        end
      end
      MODE_REMOVE: begin
        // the named page goes, wherever it sits, the front entry included
        if (lru_resident[req.page]) begin
          pos = position_of(req.page);
          for (int i = pos; i + 1 < lru_count; i++) lru_order[i] = lru_order[i+1];
          lru_resident[req.page] = 1'b0;
          lru_count--;
          res.removed = 1'b1;
        end
      end
      default: ;  // unused mode: no change, all fields zero
    endcase
  endtask

  // shadow update on every accepted input item and capacity write
  always @(posedge clk) begin
    page_req_t   req;
    lru_result_t res;
    if (!rst_n) begin
      for (int i = 0; i < NPAGES; i++) begin
        lru_order[i]    = '0;
        lru_resident[i] = 1'b0;
      end
      lru_count  = 0;
      cap_shadow = CAP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) cap_shadow = cfg_data;
      if (in_tvalid && in_tready) begin
        req.mode = in_tuser;
        req.page = in_tdata[PAGE_W-1:0];
        update_recency(req, res);
        expected_q.push_back(res);
      end
    end
  end

  // driver: bursts of items from req_q separated by random gaps when gaps_on is set
  always @(posedge clk) begin
    page_req_t nxt;
    bit        drive;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      drive = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() > 0) begin
        nxt   = req_q.pop_front();
        drive = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = gaps_on ? $urandom_range(1, 6) : 0;
        end
      end
      // one assignment to valid per edge, so back-to-back items keep it high
      in_tvalid <= drive;
      if (drive) begin
        in_tdata <= {{(IN_DATA_W-PAGE_W){1'b0}}, nxt.page};
        in_tuser <= nxt.mode;
      end
    end
  end

  // receiver: free running, random stalls, or a fixed 2-of-5 ready pattern
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_FREE:    out_tready <= 1'b1;
      RX_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: out_tready <= ((rx_tick % 5) < 2);
      default:    out_tready <= 1'b1;
    endcase
  end

  // monitor: every accepted result against the oldest expectation
  always @(posedge clk) begin
    lru_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected, tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[1] !== want.victim_valid) begin
          $error("victim_valid: expected %0d, got %0d", want.victim_valid, out_tdata[1]);
          fail_count++;
        end
        if (out_tdata[5:2] !== want.victim_page) begin
          $error("victim_page: expected %0d, got %0d", want.victim_page, out_tdata[5:2]);
          fail_count++;
        end
        if (out_tdata[6] !== want.removed) begin
          $error("removed: expected %0d, got %0d", want.removed, out_tdata[6]);
          fail_count++;
        end
      end
    end
  end

  task automatic queue_item(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] page);
    page_req_t req;
    req.mode = mode;
    req.page = page;
    req_q.push_back(req);
  endtask

  // random traffic, mostly accesses over a small hot set so hits and evictions mix
  task automatic queue_random(int n);
    int made;
    int pick;
    logic [PAGE_W-1:0] page;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      page = $urandom_range(0, 1) ? PAGE_W'($urandom_range(0, NPAGES-1))
                                  : PAGE_W'($urandom_range(0, 5));
      if (pick < 55)      queue_item(MODE_ACCESS, page);
      else if (pick < 70) queue_item(MODE_EVICT, page);
      else if (pick < 95) queue_item(MODE_REMOVE, page);
      else                queue_item(MODE_IGNORED, page);
      if (pick < 95) made++;  // ignored items do not count
    end
  endtask

  // hold the sender until every item has gone out and every result is back
  task automatic drain_all();
    while (req_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [CAP_W-1:0] cap, int n, rx_stall_t rx, bit gaps);
    write_capacity(cap);
    rx_mode = rx;
    gaps_on = gaps;
    queue_random(n);
    drain_all();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset capacity of 16
    rx_mode = RX_RANDOM;
    queue_item(MODE_EVICT, 4'd9);        // evict on empty list: no victim
    queue_item(MODE_REMOVE, 4'd3);       // remove on empty list
    queue_item(MODE_IGNORED, 4'd15);     // unused mode
    for (int p = 0; p < NPAGES; p++) queue_item(MODE_ACCESS, PAGE_W'(p));  // fill to full
    queue_item(MODE_ACCESS, 4'd15);      // hit on the most recent page
    queue_item(MODE_REMOVE, 4'd15);      // remove the front of a multi-entry list
    queue_item(MODE_REMOVE, 4'd15);      // remove of a page no longer resident
    queue_item(MODE_ACCESS, 4'd5);       // hit in the middle of the list
    queue_item(MODE_EVICT, 4'd0);        // evict the least recent page
    queue_item(MODE_IGNORED, 4'd0);
    drain_all();

    // capacity dropped below the fill count: a miss evicts just one page
    write_capacity(5'd2);
    queue_item(MODE_ACCESS, 4'd15);
    queue_item(MODE_ACCESS, 4'd15);
    queue_item(MODE_ACCESS, 4'd14);
    queue_random(90);
    drain_all();

    run_phase(5'd0,  90,  RX_PATTERN, 1'b1);  // zero acts as one frame
    run_phase(5'd31, 90,  RX_FREE,    1'b0);  // above page count, no sender gaps and no receiver stalls
    run_phase(5'd1,  90,  RX_RANDOM,  1'b1);
    run_phase(5'd16, 100, RX_PATTERN, 1'b0);
    run_phase(5'd5,  100, RX_FREE,    1'b1);
    run_phase(CAP_W'($urandom_range(1, 16)), 95, RX_RANDOM, 1'b1);
    run_phase(CAP_W'($urandom_range(1, 16)), 95, RX_PATTERN, 1'b1);

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
